FILE: rtl/aes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and byte functions of the aes block cipher core
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RkDepth = 60;
  localparam int unsigned RkAddrW = 6;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_MODE = 3'd0,
    REG_KEY_0    = 3'd1,
    REG_KEY_1    = 3'd2,
    REG_KEY_2    = 3'd3,
    REG_KEY_3    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_128 = 2'd0,
    MODE_192 = 2'd1,
    MODE_256 = 2'd2,
    MODE_UNUSED = 2'd3
  } key_mode_e;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ p;
      p = xtime(p);
    end
    gf_mul = acc;
  endfunction

  // inverse by a^254, built once per table entry at elaboration
  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] base;
    logic [7:0] e;
    r = 8'h01;
    base = a;
    e = 8'd254;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) r = gf_mul(r, base);
      base = gf_mul(base, base);
    end
    gf_inv = (a == 8'h00) ? 8'h00 : r;
  endfunction

  function automatic logic [7:0] affine(input logic [7:0] x);
    affine = 8'h63 ^ x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
             ^ {x[3:0], x[7:4]};
  endfunction

  typedef logic [7:0] sbox_t [256];

  function automatic sbox_t build_fwd();
    sbox_t t;
    for (int i = 0; i < 256; i++) t[i] = affine(gf_inv(i[7:0]));
    return t;
  endfunction

  function automatic sbox_t build_inv();
    sbox_t t;
    logic [7:0] y;
    for (int i = 0; i < 256; i++) begin
      y = affine(gf_inv(i[7:0]));
      t[y] = i[7:0];
    end
    return t;
  endfunction

  localparam sbox_t SboxFwd = build_fwd();
  localparam sbox_t SboxInv = build_inv();

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    subst_word = {SboxFwd[w[31:24]], SboxFwd[w[23:16]], SboxFwd[w[15:8]], SboxFwd[w[7:0]]};
  endfunction

endpackage

FILE: rtl/aes_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_stream_if
// valid/ready channels: data in, data out and configuration writes
// ----------------------------------------------------------------------------
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  modport source (output valid, opcode, block_hi, block_lo, input ready);
  modport sink   (input valid, opcode, block_hi, block_lo, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;
  modport source (output valid, result_hi, result_lo, input ready);
  modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/aes_rk_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_rk_mem
// round-key store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module aes_rk_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [aes_pkg::RkAddrW-1:0] waddr_i,
  input  logic [127:0]                wdata_i,
  input  logic [aes_pkg::RkAddrW-3:0] raddr_i,
  output logic [127:0]                rdata_o
);
  import aes_pkg::*;

  // one row holds the four words of a round key
  localparam int unsigned Rows = RkDepth / 4;

  logic [127:0] mem_q [Rows];

  // row write, word-aligned rows only
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i[RkAddrW-1:2]] <= wdata_i;
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/aes_key_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_key_exp
// key schedule sequencer: one word per cycle, writes one round key row
// every four words into the round-key store
// ----------------------------------------------------------------------------
module aes_key_exp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [1:0]                  key_mode_i,
  input  logic [255:0]                key_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic                        we_o,
  output logic [aes_pkg::RkAddrW-1:0] waddr_o,
  output logic [127:0]                wdata_o
);
  import aes_pkg::*;

  typedef enum logic [1:0] {
    KX_IDLE,
    KX_RUN,
    KX_DONE
  } kx_state_e;

  kx_state_e           state_q;
  logic [RkAddrW-1:0]  idx_q;      // index of the word being produced
  logic [2:0]          pos_q;      // idx mod nk
  logic [7:0]          rc_q;
  logic [31:0]         win_q [8];  // last nk words, win_q[0] is w[i-nk]
  logic [127:0]        row_q;      // words of the row under assembly
  logic [3:0]          nk;
  logic [RkAddrW-1:0]  total;
  logic [31:0]         prev;
  logic [31:0]         t;
  logic [31:0]         w_new;
  logic [31:0]         oldest;

  always_comb begin
    case (key_mode_i)
      MODE_128: begin nk = 4'd4; total = 6'd44; end
      MODE_192: begin nk = 4'd6; total = 6'd52; end
      default:  begin nk = 4'd8; total = 6'd60; end
    endcase
  end

  // next word of the schedule
  always_comb begin
    prev   = win_q[nk[2:0] - 3'd1];
    oldest = win_q[0];
    t      = prev;
    if (idx_q < {2'b00, nk}) begin
      t = key_i[255 - 32*idx_q[2:0] -: 32];
    end else if (pos_q == 3'd0) begin
      t = subst_word({prev[23:0], prev[31:24]}) ^ {rc_q, 24'h0};
    end else if (nk == 4'd8 && pos_q == 3'd4) begin
      t = subst_word(prev);
    end
    w_new = (idx_q < {2'b00, nk}) ? t : (oldest ^ t);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KX_IDLE;
      idx_q   <= '0;
      pos_q   <= '0;
      rc_q    <= 8'h01;
      done_o  <= 1'b0;
      we_o    <= 1'b0;
    end else begin
      done_o <= 1'b0;
      we_o   <= 1'b0;
      case (state_q)
        KX_IDLE: begin
          if (start_i) begin
            state_q <= KX_RUN;
            idx_q   <= '0;
            pos_q   <= '0;
            rc_q    <= 8'h01;
          end
        end
        KX_RUN: begin
          // shift window, newest at position nk-1
          for (int k = 0; k < 7; k++) win_q[k] <= win_q[k+1];
          win_q[nk[2:0] - 3'd1] <= w_new;
          row_q <= {row_q[95:0], w_new};
          if (idx_q[1:0] == 2'd3) begin
            we_o    <= 1'b1;
            waddr_o <= idx_q;
            wdata_o <= {row_q[95:0], w_new};
          end
          if (idx_q >= {2'b00, nk} && pos_q == 3'd0) rc_q <= xtime(rc_q);
          pos_q <= (pos_q == nk[2:0] - 3'd1) ? 3'd0 : pos_q + 3'd1;
          if (idx_q == total - 6'd1) begin
            state_q <= KX_DONE;
          end
          idx_q <= idx_q + 6'd1;
        end
        // last row lands in the store this cycle, report done after it
        KX_DONE: begin
          done_o  <= 1'b1;
          state_q <= KX_IDLE;
        end
        default: state_q <= KX_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q == KX_RUN);
endmodule

FILE: rtl/aes_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_round
// shared round function: one full encrypt or decrypt round, combinational
// ----------------------------------------------------------------------------
module aes_round (
  input  logic         dec_i,
  input  logic         last_i,
  input  logic [127:0] state_i,
  input  logic [127:0] rk_i,
  output logic [127:0] state_o
);
  import aes_pkg::*;

  logic [7:0] s [16];
  logic [7:0] sh [16];
  logic [7:0] sb [16];
  logic [7:0] ak [16];
  logic [7:0] mx [16];
  logic [7:0] m0, m1, m2, m3;

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = state_i[127 - 8*i -: 8];
    // shift rows, then substitution (order commutes)
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (dec_i) sh[r + 4*((c + r) % 4)] = s[r + 4*c];
        else       sh[r + 4*c] = s[r + 4*((c + r) % 4)];
      end
    end
    for (int i = 0; i < 16; i++) sb[i] = dec_i ? SboxInv[sh[i]] : SboxFwd[sh[i]];
    // decrypt adds the key before mixing, encrypt after
    for (int i = 0; i < 16; i++) ak[i] = dec_i ? (sb[i] ^ rk_i[127 - 8*i -: 8]) : sb[i];
    for (int c = 0; c < 4; c++) begin
      m0 = ak[4*c]; m1 = ak[4*c+1]; m2 = ak[4*c+2]; m3 = ak[4*c+3];
      if (dec_i) begin
        mx[4*c]   = gf_mul(8'h0e, m0) ^ gf_mul(8'h0b, m1) ^ gf_mul(8'h0d, m2) ^ gf_mul(8'h09, m3);
        mx[4*c+1] = gf_mul(8'h09, m0) ^ gf_mul(8'h0e, m1) ^ gf_mul(8'h0b, m2) ^ gf_mul(8'h0d, m3);
        mx[4*c+2] = gf_mul(8'h0d, m0) ^ gf_mul(8'h09, m1) ^ gf_mul(8'h0e, m2) ^ gf_mul(8'h0b, m3);
        mx[4*c+3] = gf_mul(8'h0b, m0) ^ gf_mul(8'h0d, m1) ^ gf_mul(8'h09, m2) ^ gf_mul(8'h0e, m3);
      end else begin
        mx[4*c]   = xtime(m0) ^ xtime(m1) ^ m1 ^ m2 ^ m3;
        mx[4*c+1] = m0 ^ xtime(m1) ^ xtime(m2) ^ m2 ^ m3;
        mx[4*c+2] = m0 ^ m1 ^ xtime(m2) ^ xtime(m3) ^ m3;
        mx[4*c+3] = xtime(m0) ^ m0 ^ m1 ^ m2 ^ xtime(m3);
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (last_i)     state_o[127 - 8*i -: 8] = ak[i] ^ (dec_i ? 8'h00 : rk_i[127 - 8*i -: 8]);
      else if (dec_i) state_o[127 - 8*i -: 8] = mx[i];
      else            state_o[127 - 8*i -: 8] = mx[i] ^ rk_i[127 - 8*i -: 8];
    end
  end
endmodule

FILE: rtl/aes_block_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher_core
// aes-128/192/256 block cipher over a round-key memory and a shared round unit
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | accepted when
//  in_if   | in  | opcode, block_hi, block_lo       | valid && ready
//  out_if  | out | result_hi, result_lo             | valid && ready
//  cfg_if  | in  | index, data (key_mode, key_0..3) | valid && ready
//
// a word passes the accepting cycle, the initial key addition, then one round
// per cycle on the round unit, the last round held while an earlier result
// waits; each round key is read from the key memory in the cycle before use.
// the first word after a key or mode write first runs the key schedule, one
// word a cycle. reset leaves the key unexpanded.
// a finished result sits in the output register; the next word is taken
// while it waits.
// ----------------------------------------------------------------------------
module aes_block_cipher_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  aes_in_if.sink        in_if,
  aes_out_if.source     out_if,
  aes_cfg_if.sink       cfg_if
);
  import aes_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PRIME,
    ST_ROUND
  } core_state_e;

  core_state_e        state_q;
  logic [1:0]         key_mode_q;
  logic [255:0]       key_q;
  logic               keys_ready_q;
  logic               op_q;
  logic [127:0]       st_q;
  logic [3:0]         rnd_q;     // rounds done
  logic [3:0]         nr;
  logic               out_valid_q;
  logic [127:0]       out_q;
  logic [RkAddrW-3:0] raddr;
  logic [127:0]       rk;
  logic               kx_busy, kx_done, kx_we;
  logic [RkAddrW-1:0] kx_waddr;
  logic [127:0]       kx_wdata;
  logic [127:0]       rnd_out;
  logic               in_take;
  logic               last_rnd;

  always_comb begin
    case (key_mode_q)
      MODE_128: nr = 4'd10;
      MODE_192: nr = 4'd12;
      default:  nr = 4'd14;
    endcase
  end

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = (state_q == ST_IDLE);
  assign in_take      = in_if.valid && in_if.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_mode_q <= MODE_256;
      key_q      <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_reg_e'(cfg_if.index))
        REG_KEY_MODE: key_mode_q <= cfg_if.data[1:0];
        REG_KEY_0:    key_q[255:192] <= cfg_if.data;
        REG_KEY_1:    key_q[191:128] <= cfg_if.data;
        REG_KEY_2:    key_q[127:64]  <= cfg_if.data;
        REG_KEY_3:    key_q[63:0]    <= cfg_if.data;
        default: ;
      endcase
    end
  end

  aes_key_exp u_kx (
    .clk_i, .rst_ni,
    .start_i   (in_take && !keys_ready_q),
    .key_mode_i(key_mode_q),
    .key_i     (key_q),
    .busy_o    (kx_busy),
    .done_o    (kx_done),
    .we_o      (kx_we),
    .waddr_o   (kx_waddr),
    .wdata_o   (kx_wdata)
  );

  // round key read in the cycle before its use; the last round keeps its key
  always_comb begin
    case (state_q)
      ST_IDLE:   raddr = (in_if.opcode == OP_DEC) ? nr : '0;
      ST_EXPAND: raddr = (op_q == OP_DEC) ? nr : '0;
      ST_PRIME:  raddr = (op_q == OP_DEC) ? (nr - 4'd1) : 4'd1;
      default: begin
        if (last_rnd) raddr = (op_q == OP_DEC) ? 4'd0 : nr;
        else          raddr = (op_q == OP_DEC) ? (nr - rnd_q - 4'd2) : (rnd_q + 4'd2);
      end
    endcase
  end

  aes_rk_mem u_mem (
    .clk_i,
    .we_i   (kx_we),
    .waddr_i(kx_waddr),
    .wdata_i(kx_wdata),
    .raddr_i(raddr),
    .rdata_o(rk)
  );

  assign last_rnd = (rnd_q == nr - 4'd1);

  aes_round u_rnd (
    .dec_i  (op_q),
    .last_i (last_rnd),
    .state_i(st_q),
    .rk_i   (rk),
    .state_o(rnd_out)
  );

  // sequencer: expand if needed, initial key add, then nr rounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      keys_ready_q <= 1'b0;
      rnd_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            op_q  <= in_if.opcode;
            st_q  <= {in_if.block_hi, in_if.block_lo};
            rnd_q <= '0;
            state_q <= keys_ready_q ? ST_PRIME : ST_EXPAND;
          end
        end
        ST_EXPAND: begin
          if (kx_done) begin
            keys_ready_q <= 1'b1;
            state_q <= ST_PRIME;
          end
        end
        ST_PRIME: begin
          // first round key is on the read port; add it
          st_q    <= st_q ^ rk;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          if (!last_rnd || !out_valid_q || out_if.ready) begin
            st_q  <= rnd_out;
            rnd_q <= rnd_q + 4'd1;
            if (last_rnd) begin
              out_q       <= rnd_out;
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cfg_if.valid && cfg_if.index <= REG_KEY_3) keys_ready_q <= 1'b0;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.result_hi = out_q[127:64];
  assign out_if.result_lo = out_q[63:0];

  // a key or mode write clears the expanded flag
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_if.valid && cfg_if.index <= REG_KEY_3 |=> !keys_ready_q)
    else $error("key write did not clear keys ready");

  // the key schedule only runs while the sequencer waits for it
  a_kx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kx_busy || kx_we) |-> state_q == ST_EXPAND)
    else $error("key memory written outside expansion");

  // the round counter never passes the round count
  a_rnd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND |-> rnd_q <= nr)
    else $error("round counter overran");
endmodule
